FILE: rtl/sipq_pkg.sv
// sipq_pkg: shared types and codes for the sorted-insert priority queue.
// Used by sipq_cell and sorted_insert_priority_queue; no dependencies.
package sipq_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 5;

  typedef enum logic {
    FUNC_ENQ = 1'b0,
    FUNC_DEQ = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Broadcast command seen by every cell in the row.
  typedef struct packed {
    logic                    enq;   // enqueue that fits
    logic                    deq;   // dequeue on a non-empty queue
    logic [PrioW-1:0]        prio;
    logic signed [DataW-1:0] data;
  } sipq_cmd_t;

  // What one cell hands to its neighbors.
  typedef struct packed {
    logic                    gt;    // empty, or holds a larger priority than the command
    logic [PrioW-1:0]        prio;
    logic signed [DataW-1:0] data;
  } sipq_link_t;

endpackage

FILE: rtl/sorted_insert_priority_queue.sv
// sorted_insert_priority_queue: top level, a row of DEPTH sipq_cell slots
// plus fill counter and output register. Depends on sipq_pkg and sipq_cell.

// Priority queue of DEPTH entries kept sorted in a row of cells, head at
// cell 0. Every cell compares its priority with the incoming one in the
// same cycle, so one word is accepted per cycle while the input does not
// stall, and its result word is captured in the output register on the
// next edge. The input stalls only while the output register holds a
// word that the receiver stalls. Equal priorities leave in arrival order.
// Status: ok, overflow (enqueue while full, queue unchanged) or empty
// (dequeue while empty, data zero). fill_count is the entry count after
// the operation, taken modulo 32. No clearing pass after reset.
module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic signed [sipq_pkg::DataW-1:0] data_in_i,
  input  logic [sipq_pkg::PrioW-1:0]        priority_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [sipq_pkg::DataW-1:0] data_out_o,
  output logic [sipq_pkg::StatusW-1:0]      status_o,
  output logic [sipq_pkg::FillW-1:0]        fill_count_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]                   count_q, count_d;
  logic                              out_valid_q;
  logic signed [sipq_pkg::DataW-1:0] data_out_q, data_out_d;
  sipq_pkg::status_e                 status_q, status_d;
  logic [sipq_pkg::FillW-1:0]        fill_q;

  logic                 accept, is_enq, full, empty;
  sipq_pkg::sipq_cmd_t  cmd;
  sipq_pkg::sipq_link_t link [DEPTH];
  sipq_pkg::sipq_link_t left_in [DEPTH];
  sipq_pkg::sipq_link_t right_in [DEPTH];

  // Output register frees itself when taken, so a new word can enter.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_enq     = (sipq_pkg::func_e'(func_i) == sipq_pkg::FUNC_ENQ);
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  assign cmd.enq  = accept && is_enq && !full;
  assign cmd.deq  = accept && !is_enq && !empty;
  assign cmd.prio = priority_in_i;
  assign cmd.data = data_in_i;

  // Row of cells. Cell 0 sees a "not greater" head neighbor so a new
  // smallest entry lands there; the tail's right neighbor is don't-care
  // since a dequeue drops the tail slot from the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_in[i] = '{gt: 1'b0, prio: '0, data: '0};
    end else begin : g_mid
      assign left_in[i] = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in[i] = link[i];
    end else begin : g_body
      assign right_in[i] = link[i+1];
    end

    sipq_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .occupied_i (count_q > CntW'(i)),
      .left_i     (left_in[i]),
      .right_i    (right_in[i]),
      .link_o     (link[i])
    );
  end

  always_comb begin
    count_d    = count_q;
    data_out_d = '0;
    status_d   = sipq_pkg::ST_OK;
    if (is_enq) begin
      if (full) begin
        status_d = sipq_pkg::ST_OVERFLOW;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else begin
      if (empty) begin
        status_d = sipq_pkg::ST_EMPTY;
      end else begin
        count_d    = count_q - CntW'(1);
        data_out_d = link[0].data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_out_q <= data_out_d;
      status_q   <= status_d;
      fill_q     <= sipq_pkg::FillW'(count_d);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign data_out_o   = data_out_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

  // Count never passes capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("entry count above capacity");

  // Head two entries stay in priority order.
  a_sorted_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (link[0].prio <= link[1].prio))
    else $error("head entries out of order");

  // Enqueue on a full queue reports overflow and keeps the count.
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_enq && full) |=>
      (status_q == sipq_pkg::ST_OVERFLOW) && (count_q == CntW'(DEPTH)))
    else $error("full enqueue not flagged");

  // A failed operation returns zero data.
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != sipq_pkg::ST_OK)) |-> (data_out_q == '0))
    else $error("data on failed operation");

endmodule

FILE: rtl/sipq_cell.sv
// sipq_cell: one slot of the sorted row; holds a data word and its priority.
// Depends on sipq_pkg.
module sipq_cell (
  input  logic                 clk_i,
  input  sipq_pkg::sipq_cmd_t  cmd_i,
  input  logic                 occupied_i,  // slot index below the fill count
  input  sipq_pkg::sipq_link_t left_i,      // neighbor nearer the head
  input  sipq_pkg::sipq_link_t right_i,     // neighbor nearer the tail
  output sipq_pkg::sipq_link_t link_o
);

  logic [sipq_pkg::PrioW-1:0]        prio_q, prio_d;
  logic signed [sipq_pkg::DataW-1:0] data_q, data_d;
  logic                              gt;

  // New word goes ahead of strictly larger priorities only (FIFO on ties).
  assign gt = !occupied_i || (prio_q > cmd_i.prio);

  always_comb begin
    prio_d = prio_q;
    data_d = data_q;
    if (cmd_i.deq) begin
      prio_d = right_i.prio;
      data_d = right_i.data;
    end else if (cmd_i.enq && gt) begin
      if (left_i.gt) begin
        prio_d = left_i.prio;
        data_d = left_i.data;
      end else begin
        prio_d = cmd_i.prio;
        data_d = cmd_i.data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    data_q <= data_d;
  end

  assign link_o.gt   = gt;
  assign link_o.prio = prio_q;
  assign link_o.data = data_q;

endmodule

FILE: verif/sorted_insert_priority_queue_tb.sv
// sorted_insert_priority_queue_tb: self-checking bench for the sorted-insert priority queue.
// Needs sipq_pkg and sorted_insert_priority_queue from rtl/; it reads no files.
// A directed table runs first, then random enqueue/dequeue traffic, checked by a predictor.
module sorted_insert_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth      = 16;
  localparam int NumRandom  = 1325;
  localparam int CycleLimit = 300000;
  localparam int HoldStart  = 1100;   // word index where the long output hold-off begins
  localparam int HoldCycles = 80;

  // One result word of the queue.
  typedef struct packed {
    logic signed [sipq_pkg::DataW-1:0] data;
    sipq_pkg::status_e                 status;
    logic [sipq_pkg::FillW-1:0]        fill;
  } qres_t;

  // One input word plus, for the rows that allow it, its result typed in by hand.
  typedef struct packed {
    sipq_pkg::func_e                   op;
    logic signed [sipq_pkg::DataW-1:0] data;
    logic [sipq_pkg::PrioW-1:0]        prio;
    logic                              typed;
    qres_t                             want;
  } qword_t;

  localparam qres_t NoRes = '{data: '0, status: sipq_pkg::ST_OK, fill: '0};

  // Directed table. Typed rows: empty queue, extremes, equal-priority order,
  // error codes. The sixteen fill rows mix ties and extremes and go to the predictor;
  // the last row enqueues into a full queue.
  localparam qword_t DirRows [25] = '{
    '{sipq_pkg::FUNC_DEQ, 32'sh0000_0000, 8'd0,   1'b1,
      '{32'sh0000_0000, sipq_pkg::ST_EMPTY,    5'd0}},
    '{sipq_pkg::FUNC_ENQ, 32'sh7FFF_FFFF, 8'd255, 1'b1,
      '{32'sh0000_0000, sipq_pkg::ST_OK,       5'd1}},
    '{sipq_pkg::FUNC_ENQ, 32'sh8000_0000, 8'd0,   1'b1,
      '{32'sh0000_0000, sipq_pkg::ST_OK,       5'd2}},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0001, 8'd0,   1'b1,
      '{32'sh0000_0000, sipq_pkg::ST_OK,       5'd3}},
    '{sipq_pkg::FUNC_DEQ, 32'shFFFF_FFFF, 8'd255, 1'b1,
      '{32'sh8000_0000, sipq_pkg::ST_OK,       5'd2}},
    '{sipq_pkg::FUNC_DEQ, 32'sh0000_0000, 8'd0,   1'b1,
      '{32'sh0000_0001, sipq_pkg::ST_OK,       5'd1}},
    '{sipq_pkg::FUNC_DEQ, 32'sh0000_0000, 8'd0,   1'b1,
      '{32'sh7FFF_FFFF, sipq_pkg::ST_OK,       5'd0}},
    '{sipq_pkg::FUNC_DEQ, 32'sh1234_5678, 8'd17,  1'b1,
      '{32'sh0000_0000, sipq_pkg::ST_EMPTY,    5'd0}},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0010, 8'd5,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0011, 8'd5,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0012, 8'd255, 1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0013, 8'd0,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'shDEAD_BEEF, 8'd128, 1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0015, 8'd5,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0016, 8'd0,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_0017, 8'd255, 1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh5555_5555, 8'd1,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'shAAAA_AAAA, 8'd254, 1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_001A, 8'd128, 1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_001B, 8'd7,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_001C, 8'd7,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_001D, 8'd3,   1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_001E, 8'd200, 1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'sh0000_001F, 8'd64,  1'b0, NoRes},
    '{sipq_pkg::FUNC_ENQ, 32'shFFFF_FFFF, 8'd0,   1'b1,
      '{32'sh0000_0000, sipq_pkg::ST_OVERFLOW, 5'd16}}
  };

  // Block ports; every input starts at a known value.
  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_stall_o;
  logic                              func_i        = 1'b0;
  logic signed [sipq_pkg::DataW-1:0] data_in_i     = '0;
  logic [sipq_pkg::PrioW-1:0]        priority_in_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i   = 1'b0;
  logic signed [sipq_pkg::DataW-1:0] data_out_o;
  logic [sipq_pkg::StatusW-1:0]      status_o;
  logic [sipq_pkg::FillW-1:0]        fill_count_o;

  // Predictor state: a sorted copy of the queue, head at slot 0.
  logic signed [sipq_pkg::DataW-1:0] slot_data [Depth];
  logic [sipq_pkg::PrioW-1:0]        slot_prio [Depth];
  int                                held = 0;

  qword_t stim_words [$];     // every word in send order
  qres_t  expected_res [$];   // results still owed by the block
  int     words_taken   = 0;  // words accepted by the block
  int     words_sent    = 0;
  int     results_seen  = 0;
  int     mismatches    = 0;
  int     cycle_count   = 0;
  int     tx_idle_pct   = 25;
  int     rx_idle_pct   = 64;
  logic   rx_hold       = 1'b0;

  sorted_insert_priority_queue #(
    .DEPTH(Depth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .data_in_i    (data_in_i),
    .priority_in_i(priority_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .data_out_o   (data_out_o),
    .status_o     (status_o),
    .fill_count_o (fill_count_o)
  );

  // 20 ns clock.
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Runaway guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // One line per mismatch; printing stops after 40 so a broken build stays readable.
  task automatic report(input string what, input logic [sipq_pkg::DataW-1:0] got,
                        input logic [sipq_pkg::DataW-1:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on result %0d, %s: got %0h, want %0h", results_seen, what, got, want);
  endtask

  // Applies one operation to the predicted queue and returns its result word.
  // Enqueue goes behind every entry of lower or equal priority (FIFO on ties).
  function automatic qres_t queue_step(input sipq_pkg::func_e op,
                                       input logic signed [sipq_pkg::DataW-1:0] word,
                                       input logic [sipq_pkg::PrioW-1:0] prio);
    qres_t r;
    int    pos;
    int    i;
    r = NoRes;
    if (op == sipq_pkg::FUNC_ENQ) begin
      if (held >= Depth) begin
        r.status = sipq_pkg::ST_OVERFLOW;
      end else begin
        pos = 0;
        while (pos < held && slot_prio[pos] <= prio) pos++;
        for (i = held; i > pos; i--) begin
          slot_data[i] = slot_data[i-1];
          slot_prio[i] = slot_prio[i-1];
        end
        slot_data[pos] = word;
        slot_prio[pos] = prio;
        held++;
      end
    end else if (held == 0) begin
      r.status = sipq_pkg::ST_EMPTY;
    end else begin
      r.data = slot_data[0];
      for (i = 1; i < held; i++) begin
        slot_data[i-1] = slot_data[i];
        slot_prio[i-1] = slot_prio[i];
      end
      held--;
    end
    r.fill = sipq_pkg::FillW'(held);
    return r;
  endfunction

  // Random word; the mode sets how hard the traffic leans toward filling or draining.
  function automatic qword_t random_word(input int mode);
    qword_t w;
    int     deq_pct;
    w = '{op: sipq_pkg::FUNC_ENQ, data: '0, prio: '0, typed: 1'b0, want: NoRes};
    deq_pct = (mode == 0) ? 20 : (mode == 1) ? 75 : 50;
    w.op = ($urandom_range(99) < deq_pct) ? sipq_pkg::FUNC_DEQ : sipq_pkg::FUNC_ENQ;
    case ($urandom_range(3))
      0: w.prio = sipq_pkg::PrioW'($urandom_range(3));        // crowd of ties
      1: begin
        case ($urandom_range(3))
          0: w.prio = 8'd0;
          1: w.prio = 8'd255;
          2: w.prio = 8'd1;
          default: w.prio = 8'd254;
        endcase
      end
      default: w.prio = sipq_pkg::PrioW'($urandom_range(255));
    endcase
    if ($urandom_range(15) == 0) begin
      case ($urandom_range(3))
        0: w.data = 32'sh8000_0000;
        1: w.data = 32'sh7FFF_FFFF;
        2: w.data = 32'sh0000_0000;
        default: w.data = 32'shFFFF_FFFF;
      endcase
    end else begin
      w.data = $urandom;
    end
    return w;
  endfunction

  // Receiver: random stall, overridden by the long hold-off.
  always @(posedge clk_i) begin
    out_stall_i <= rx_hold || ($urandom_range(99) < rx_idle_pct);
  end

  // Long hold-off: the output stays stalled while the sender keeps offering
  // words, so the output register backs up and the input stalls.
  initial begin
    wait (words_sent >= HoldStart);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Monitor: prices each accepted word and checks each accepted result.
  // Runs on pre-edge values, the bench drives with nonblocking assignments.
  always @(posedge clk_i) begin : monitor
    qres_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        want = queue_step(sipq_pkg::func_e'(func_i), data_in_i, priority_in_i);
        if (stim_words[words_taken].typed) want = stim_words[words_taken].want;
        expected_res.push_back(want);
        words_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_res.size() == 0) begin
          report("result word with nothing pending", data_out_o, '0);
        end else begin
          want = expected_res.pop_front();
          if (data_out_o !== want.data)
            report("data_out", data_out_o, want.data);
          if (status_o !== want.status)
            report("status", sipq_pkg::DataW'(status_o), sipq_pkg::DataW'(want.status));
          if (fill_count_o !== want.fill)
            report("fill_count", sipq_pkg::DataW'(fill_count_o),
                   sipq_pkg::DataW'(want.fill));
        end
        results_seen++;
      end
    end
  end

  // Sender and run control.
  initial begin : sender
    int mode;
    int n;
    mode = 2;
    foreach (DirRows[k]) stim_words.push_back(DirRows[k]);
    for (n = 0; n < NumRandom; n++) begin
      if (n % 32 == 0) mode = $urandom_range(2);
      stim_words.push_back(random_word(mode));
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < stim_words.size(); n++) begin
      // Idle mix: sender light / receiver heavy, then swapped, then none.
      if (n < 450) begin
        tx_idle_pct = 25;
        rx_idle_pct = 64;
      end else if (n < 900) begin
        tx_idle_pct = 64;
        rx_idle_pct = 25;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i    <= 1'b1;
      func_i        <= stim_words[n].op;
      data_in_i     <= stim_words[n].data;
      priority_in_i <= stim_words[n].prio;
      @(posedge clk_i);
      while (in_stall_o) @(posedge clk_i);
      words_sent = n + 1;
    end
    in_valid_i <= 1'b0;

    // Drain, then wait quietly to catch stray result words.
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/sipq_pkg.sv
rtl/sipq_cell.sv
rtl/sorted_insert_priority_queue.sv
verif/sorted_insert_priority_queue_tb.sv
